### design/gtif_pkg.sv
// ----------------------------------------------------------------------------
// gtif_pkg
// Shared types and constants of the good time interval filter: command codes,
// the request and result items, and the controller to datapath signal groups.
// ----------------------------------------------------------------------------
package gtif_pkg;

    localparam int GOOD_DEPTH_DEF = 16;
    localparam int BAD_DEPTH_DEF  = 16;
    localparam int TIME_W         = 63;

    localparam logic [TIME_W-1:0] OPEN_STOP_NS_DEF = 63'd2000000000000000000;

    localparam logic [2:0] CMD_CLEAR    = 3'd0;
    localparam logic [2:0] CMD_OPEN     = 3'd1;
    localparam logic [2:0] CMD_ADD_GOOD = 3'd2;
    localparam logic [2:0] CMD_ADD_BAD  = 3'd3;
    localparam logic [2:0] CMD_QUERY    = 3'd4;

    typedef struct packed {
        logic [2:0]        command;
        logic [TIME_W-1:0] event_time;
        logic [TIME_W-1:0] span_start;
        logic [TIME_W-1:0] span_stop;
    } in_t;

    typedef struct packed {
        logic is_good;
        logic status;
    } out_t;

    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] stop;
    } span_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic open;
        logic write_good;
        logic write_bad;
        logic scan_clear;
        logic rd_en;
        logic sel_bad;
    } ctl_t;

    typedef struct packed {
        logic good_empty;
        logic good_full;
        logic bad_empty;
        logic bad_full;
        logic hit;
        logic last_data;
    } stat_t;

endpackage

### design/gtif_ctrl.sv
// ----------------------------------------------------------------------------
// gtif_ctrl
// Command sequencer: decodes each item, steers table writes and the entry
// scans of a query, and registers the result with its strobe.
// ----------------------------------------------------------------------------
module gtif_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2:0]      command,
    input  gtif_pkg::stat_t stat,
    output gtif_pkg::ctl_t  ctl,
    output logic            busy,
    output logic            done,
    output gtif_pkg::out_t  result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_GOOD,
        ST_SCAN_BAD
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    logic [2:0]     cmd_reg;
    logic           done_reg;
    logic           done_next;
    gtif_pkg::out_t result_reg;
    gtif_pkg::out_t result_next;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = '0;
        ctl         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                case (cmd_reg)
                    gtif_pkg::CMD_CLEAR:
                    begin
                        ctl.clear = 1'b1;
                    end
                    gtif_pkg::CMD_OPEN:
                    begin
                        ctl.open = 1'b1;
                    end
                    gtif_pkg::CMD_ADD_GOOD:
                    begin
                        ctl.write_good     = !stat.good_full;
                        result_next.status = stat.good_full;
                    end
                    gtif_pkg::CMD_ADD_BAD:
                    begin
                        ctl.write_bad      = !stat.bad_full;
                        result_next.status = stat.bad_full;
                    end
                    gtif_pkg::CMD_QUERY:
                    begin
                        if (!stat.good_empty)
                        begin
                            state_next = ST_SCAN_GOOD;
                            done_next  = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SCAN_GOOD:
            begin
                if (stat.hit)
                begin
                    if (stat.bad_empty)
                    begin
                        state_next          = ST_IDLE;
                        done_next           = 1'b1;
                        result_next.is_good = 1'b1;
                    end
                    else
                    begin
                        ctl.scan_clear = 1'b1;
                        state_next     = ST_SCAN_BAD;
                    end
                end
                else if (stat.last_data)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    ctl.rd_en = 1'b1;
                end
            end
            ST_SCAN_BAD:
            begin
                ctl.sel_bad = 1'b1;
                if (stat.hit)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else if (stat.last_data)
                begin
                    state_next          = ST_IDLE;
                    done_next           = 1'b1;
                    result_next.is_good = 1'b1;
                end
                else
                begin
                    ctl.rd_en = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cmd_reg    <= gtif_pkg::CMD_CLEAR;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            result_reg <= result_next;
            if (ctl.load)
            begin
                cmd_reg <= command;
            end
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### design/gtif_datapath.sv
// ----------------------------------------------------------------------------
// gtif_datapath
// Interval tables with fill counts, the scan address counter, registered
// table reads and the inclusive range compare against the queried time.
// ----------------------------------------------------------------------------
module gtif_datapath
#(
    parameter int                              GOOD_DEPTH   = gtif_pkg::GOOD_DEPTH_DEF,
    parameter int                              BAD_DEPTH    = gtif_pkg::BAD_DEPTH_DEF,
    parameter logic [gtif_pkg::TIME_W-1:0]     OPEN_STOP_NS = gtif_pkg::OPEN_STOP_NS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  gtif_pkg::in_t   request,
    input  gtif_pkg::ctl_t  ctl,
    output gtif_pkg::stat_t stat
);

    localparam int GCW  = $clog2(GOOD_DEPTH + 1);
    localparam int BCW  = $clog2(BAD_DEPTH + 1);
    localparam int GI_W = (GOOD_DEPTH > 1) ? $clog2(GOOD_DEPTH) : 1;
    localparam int BI_W = (BAD_DEPTH > 1) ? $clog2(BAD_DEPTH) : 1;
    localparam int SW   = (GCW > BCW) ? GCW : BCW;

    gtif_pkg::span_t good_mem [GOOD_DEPTH];
    gtif_pkg::span_t bad_mem [BAD_DEPTH];
    gtif_pkg::span_t good_q_reg;
    gtif_pkg::span_t bad_q_reg;
    gtif_pkg::span_t span_reg;
    gtif_pkg::span_t cmp_span;

    logic [gtif_pkg::TIME_W-1:0] time_reg;
    logic [GCW-1:0]              good_count_reg;
    logic [BCW-1:0]              bad_count_reg;
    logic                        open_flag_reg;
    logic [SW-1:0]               scan_idx_reg;
    logic [SW-1:0]               cnt_sel;
    logic                        rd_valid_reg;
    logic                        rd_last_reg;
    logic                        rd_sel_reg;
    logic                        rd_open_reg;
    logic                        issue;
    logic                        in_range;

    assign cnt_sel  = ctl.sel_bad ? SW'(bad_count_reg) : SW'(good_count_reg);
    assign issue    = ctl.rd_en && (scan_idx_reg < cnt_sel);

    assign cmp_span = rd_open_reg ? gtif_pkg::span_t'{start: '0, stop: OPEN_STOP_NS}
                    : (rd_sel_reg ? bad_q_reg : good_q_reg);
    assign in_range = (time_reg >= cmp_span.start) && (time_reg <= cmp_span.stop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            good_count_reg <= GCW'(1);
            bad_count_reg  <= '0;
            open_flag_reg  <= 1'b1;
            scan_idx_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            rd_sel_reg     <= 1'b0;
            rd_open_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                good_count_reg <= '0;
                bad_count_reg  <= '0;
                open_flag_reg  <= 1'b0;
            end
            else if (ctl.open)
            begin
                good_count_reg <= GCW'(1);
                bad_count_reg  <= '0;
                open_flag_reg  <= 1'b1;
            end
            else if (ctl.write_good)
            begin
                good_count_reg <= good_count_reg + GCW'(1);
                if (good_count_reg == '0)
                begin
                    open_flag_reg <= 1'b0;
                end
            end
            else if (ctl.write_bad)
            begin
                bad_count_reg <= bad_count_reg + BCW'(1);
            end

            if (ctl.load || ctl.scan_clear)
            begin
                scan_idx_reg <= '0;
                rd_valid_reg <= 1'b0;
                rd_last_reg  <= 1'b0;
            end
            else
            begin
                rd_valid_reg <= issue;
                if (issue)
                begin
                    scan_idx_reg <= scan_idx_reg + SW'(1);
                    rd_last_reg  <= ((scan_idx_reg + SW'(1)) == cnt_sel);
                    rd_sel_reg   <= ctl.sel_bad;
                    rd_open_reg  <= !ctl.sel_bad && open_flag_reg && (scan_idx_reg == '0);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            time_reg       <= request.event_time;
            span_reg.start <= request.span_start;
            span_reg.stop  <= request.span_stop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.write_good)
        begin
            good_mem[good_count_reg[GI_W-1:0]] <= span_reg;
        end
        if (issue && !ctl.sel_bad)
        begin
            good_q_reg <= good_mem[scan_idx_reg[GI_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.write_bad)
        begin
            bad_mem[bad_count_reg[BI_W-1:0]] <= span_reg;
        end
        if (issue && ctl.sel_bad)
        begin
            bad_q_reg <= bad_mem[scan_idx_reg[BI_W-1:0]];
        end
    end

    assign stat.good_empty = (good_count_reg == '0);
    assign stat.good_full  = (good_count_reg == GCW'(GOOD_DEPTH));
    assign stat.bad_empty  = (bad_count_reg == '0);
    assign stat.bad_full   = (bad_count_reg == BCW'(BAD_DEPTH));
    assign stat.hit        = rd_valid_reg && in_range;
    assign stat.last_data  = rd_valid_reg && rd_last_reg;

endmodule

### design/good_time_interval_filter.sv
// ----------------------------------------------------------------------------
// good_time_interval_filter
// Good and bad time interval tables with append, clear, open and query items.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and its result appears
// on result for the single cycle that done is high; the receiver cannot stall,
// so it must take every result in that cycle. Clear, open, append and unknown
// commands pass from the execute state straight back to idle. A query scans
// only the filled entries of the good and bad tables; each table has one read
// port with a registered output and the scan checks one entry per cycle; the
// good scan stops at the first match and the bad scan is skipped when no good
// interval matches.
// Reset leaves the open interval from zero to OPEN_STOP_NS installed.
module good_time_interval_filter
#(
    parameter int                          GOOD_DEPTH   = gtif_pkg::GOOD_DEPTH_DEF,
    parameter int                          BAD_DEPTH    = gtif_pkg::BAD_DEPTH_DEF,
    parameter logic [gtif_pkg::TIME_W-1:0] OPEN_STOP_NS = gtif_pkg::OPEN_STOP_NS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  gtif_pkg::in_t  request,
    output logic           done,
    output gtif_pkg::out_t result
);

    gtif_pkg::ctl_t  ctl;
    gtif_pkg::stat_t stat;

    gtif_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (request.command),
        .stat    (stat),
        .ctl     (ctl),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    gtif_datapath
    #(
        .GOOD_DEPTH   (GOOD_DEPTH),
        .BAD_DEPTH    (BAD_DEPTH),
        .OPEN_STOP_NS (OPEN_STOP_NS)
    )
    u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctl     (ctl),
        .stat    (stat)
    );

endmodule

### design/gtif_checker.sv
// ----------------------------------------------------------------------------
// gtif_checker
// Port level checks of the filter's command handshake and result strobe.
// ----------------------------------------------------------------------------
module gtif_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input gtif_pkg::out_t result
);

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted item did not raise busy.");

    a_done_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Result strobe while still busy.");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe held for more than one cycle.");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(busy))
        else $error("Result appeared without an item in progress.");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_good) |-> !result.status)
        else $error("Good time reported together with a refused append.");

endmodule

bind good_time_interval_filter gtif_checker u_gtif_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);
